### rtl/pbb_pkg.sv
`default_nettype none

package pbb_pkg;

   localparam int COORD_FRAC_BITS = 24;
   localparam int RAND_BITS       = 24;
   localparam int COORD_W         = 32;
   localparam int POINT_Y_W       = 40;
   localparam int ROOT_W          = (COORD_W + COORD_FRAC_BITS + 1) / 2;
   localparam int TRIM_W          = ROOT_W + 2;
   localparam int PROD_W          = 2 * COORD_W;
   localparam int PEN_W           = PROD_W + 6;
   localparam int Y_W             = COORD_W + 4;
   localparam int IDX_W           = 3;
   localparam int CORNERS         = 4;

   // root unit source index for the stored upper x corner
   localparam logic [IDX_W-1:0] XROOT_IDX = IDX_W'(4);
   localparam logic [IDX_W-1:0] LAST_CORNER = IDX_W'(3);
   localparam logic [IDX_W-1:0] LAST_TRIM = IDX_W'(5);

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_TRIAL = 1'b1;

   typedef enum logic [1:0] {
      MODE_UNABLE = 2'd0,
      MODE_FULL   = 2'd1,
      MODE_PAR    = 2'd2,
      MODE_BOX    = 2'd3
   } mode_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_ROOT_START,
      OP_ROOT_STORE,
      OP_TRIM,
      OP_CHECK,
      OP_CLEAR,
      OP_SQR_MUL,
      OP_SQR_WR,
      OP_FULL_MODE,
      OP_PEN_MUL,
      OP_PEN_SCALE,
      OP_PEN_CMP,
      OP_TX_MUL,
      OP_TX_ADD,
      OP_TY_MUL,
      OP_TY_ADD,
      OP_TE_MUL,
      OP_T_ACC,
      OP_PUBLISH
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [IDX_W-1:0] idx;
   } dp_cmd_type;

   typedef struct packed {
      logic root_done;
      logic empty;
      logic full;
      logic par_mode;
   } dp_stat_type;

endpackage

`default_nettype wire

### rtl/pbb_ifs.sv
`default_nettype none

interface pbb_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [31:0] box_low_x;
   logic [31:0] box_low_y;
   logic [31:0] box_high_x;
   logic [31:0] box_high_y;
   logic [23:0] rand_x;
   logic [23:0] rand_y;

   modport source (output valid, command, box_low_x, box_low_y, box_high_x, box_high_y,
                   rand_x, rand_y, input ready);
   modport sink (input valid, command, box_low_x, box_low_y, box_high_x, box_high_y,
                 rand_x, rand_y, output ready);
endinterface

interface pbb_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         sample_mode;
   logic [31:0]        trim_low_x;
   logic [31:0]        trim_low_y;
   logic [31:0]        trim_high_x;
   logic [31:0]        trim_high_y;
   logic [31:0]        point_x;
   logic signed [39:0] point_y;
   logic               accepted;

   modport source (output valid, sample_mode, trim_low_x, trim_low_y, trim_high_x,
                   trim_high_y, point_x, point_y, accepted, input ready);
   modport sink (input valid, sample_mode, trim_low_x, trim_low_y, trim_high_x,
                 trim_high_y, point_x, point_y, accepted, output ready);
endinterface

`default_nettype wire

### rtl/parabolic_band_box_sampler.sv
// Channel   Direction  Handshake      Word
// req_chan  in         valid / ready  command, box corners, rand_x, rand_y
// rsp_chan  out        valid / ready  sample_mode, trimmed corners, point, accepted
//
// One word at a time. A load makes four passes through the shared root unit
// (start, 28 root bits, store), then six trim steps, the squaring steps, a fifth
// root pass and, unless the box is full, the penalty steps; an empty box ends after
// the trim check. A trial runs the x, y and acceptance steps in parallelogram mode only.
// Reset (synchronous) leaves an unable box with all corners zero.
// The result sits in an output register; a new word is taken while it waits.
// A stalled result holds the next one in its final state until taken.
`default_nettype none

module parabolic_band_box_sampler (
   input wire logic   clock,
   input wire logic   reset,
   pbb_req_if.sink    req_chan,
   pbb_rsp_if.source  rsp_chan
);

   pbb_pkg::dp_cmd_type  cmd;
   pbb_pkg::dp_stat_type stat;

   // sequencer: handshakes and step order
   pbb_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_command (req_chan.command),
      .req_ready   (req_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .stat        (stat),
      .cmd         (cmd)
   );

   // datapath: root unit, shared multiplier, box state, output register
   pbb_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .box_low_x   (req_chan.box_low_x),
      .box_low_y   (req_chan.box_low_y),
      .box_high_x  (req_chan.box_high_x),
      .box_high_y  (req_chan.box_high_y),
      .rand_x      (req_chan.rand_x),
      .rand_y      (req_chan.rand_y),
      .sample_mode (rsp_chan.sample_mode),
      .trim_low_x  (rsp_chan.trim_low_x),
      .trim_low_y  (rsp_chan.trim_low_y),
      .trim_high_x (rsp_chan.trim_high_x),
      .trim_high_y (rsp_chan.trim_high_y),
      .point_x     (rsp_chan.point_x),
      .point_y     (rsp_chan.point_y),
      .accepted    (rsp_chan.accepted)
   );

endmodule

`default_nettype wire

### rtl/pbb_sqrt.sv
`default_nettype none

// restoring square root of radicand * 2^F, one root bit per cycle
module pbb_sqrt (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [pbb_pkg::COORD_W-1:0] radicand,
   output logic      [pbb_pkg::ROOT_W-1:0]  root,
   output logic                             done
);

   localparam int RAD_W = 2 * pbb_pkg::ROOT_W;
   localparam int REM_W = pbb_pkg::ROOT_W + 2;
   localparam int CNT_W = $clog2(pbb_pkg::ROOT_W);

   logic [RAD_W-1:0]          rad_ff, rad_in;
   logic [REM_W-1:0]          rem_ff, rem_in;
   logic [pbb_pkg::ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [REM_W+1:0]          rem_sh;
   logic [REM_W+1:0]          trial;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff, rad_ff[RAD_W-1 -: 2]};
      trial   = (REM_W+2)'({root_ff, 2'b01});
      if (start) begin
         rad_in  = RAD_W'({radicand, pbb_pkg::COORD_FRAC_BITS'(0)});
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(pbb_pkg::ROOT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = REM_W'(rem_sh - trial);
            root_in = {root_ff[pbb_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = REM_W'(rem_sh);
            root_in = {root_ff[pbb_pkg::ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign root = root_ff;
   assign done = done_ff;

   no_restart_while_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("root unit restarted while busy");

   start_makes_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff) else $error("root unit did not start");

   done_only_when_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("root unit flagged done while busy");

endmodule

`default_nettype wire

### rtl/pbb_datapath.sv
`default_nettype none

module pbb_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire pbb_pkg::dp_cmd_type           cmd,
   output pbb_pkg::dp_stat_type               stat,
   input  wire logic [31:0]                   box_low_x,
   input  wire logic [31:0]                   box_low_y,
   input  wire logic [31:0]                   box_high_x,
   input  wire logic [31:0]                   box_high_y,
   input  wire logic [pbb_pkg::RAND_BITS-1:0] rand_x,
   input  wire logic [pbb_pkg::RAND_BITS-1:0] rand_y,
   output logic [1:0]                         sample_mode,
   output logic [31:0]                        trim_low_x,
   output logic [31:0]                        trim_low_y,
   output logic [31:0]                        trim_high_x,
   output logic [31:0]                        trim_high_y,
   output logic [31:0]                        point_x,
   output logic signed [39:0]                 point_y,
   output logic                               accepted
);

   localparam int CW = pbb_pkg::COORD_W;
   localparam int TW = pbb_pkg::TRIM_W;
   localparam int F  = pbb_pkg::COORD_FRAC_BITS;
   localparam int YW = pbb_pkg::Y_W;
   localparam int POINT_Y_W_L = pbb_pkg::POINT_Y_W;
   localparam logic signed [TW-1:0] ONE = TW'(1) << F;

   logic [CW-1:0]                box_ff [pbb_pkg::CORNERS];
   logic [pbb_pkg::RAND_BITS-1:0] rnd_x_ff, rnd_y_ff;
   logic signed [TW-1:0]         r_ff [pbb_pkg::CORNERS];
   logic signed [TW-1:0]         r_in [pbb_pkg::CORNERS];
   logic [CW-1:0]                corner_ff [pbb_pkg::CORNERS];
   pbb_pkg::mode_type            mode_ff;
   logic [pbb_pkg::ROOT_W-1:0]   root_hx_ff;
   logic                         full_ff;
   logic [pbb_pkg::PROD_W-1:0]   prod_ff;
   logic [pbb_pkg::PEN_W-1:0]    pen_lhs_ff, pen_rhs_ff;
   logic [CW-1:0]                x_ff;
   logic signed [YW-1:0]         y_ff;
   logic [CW-1:0]                ae_ff;
   logic                         acc_ff;

   logic [1:0]                   out_mode_ff;
   logic [CW-1:0]                out_corner_ff [pbb_pkg::CORNERS];
   logic [CW-1:0]                out_x_ff;
   logic signed [POINT_Y_W_L-1:0] out_y_ff;
   logic                         out_acc_ff;

   logic [CW-1:0]                mul_a, mul_b;
   logic [pbb_pkg::PROD_W-1:0]   mul_p;
   logic                         root_start;
   logic [CW-1:0]                root_src;
   logic [pbb_pkg::ROOT_W-1:0]   root_val;
   logic                         root_done;
   logic [1:0]                   cidx;
   logic [CW-1:0]                diff_y, diff_x;
   logic [CW:0]                  x_sum;
   logic [CW-1:0]                t_val;
   logic [CW:0]                  e_val;
   logic [YW-1:0]                y_val;
   logic [CW-1:0]                sq_sat;

   assign cidx = cmd.idx[1:0];

   // root unit source: box corners, or the stored upper x corner
   assign root_start = (cmd.op == pbb_pkg::OP_ROOT_START);
   assign root_src   = (cmd.idx == pbb_pkg::XROOT_IDX) ? corner_ff[2] : box_ff[cidx];

   pbb_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (root_src),
      .root     (root_val),
      .done     (root_done)
   );

   assign diff_y = (corner_ff[3] >= corner_ff[1]) ? corner_ff[3] - corner_ff[1] : '0;
   assign diff_x = (corner_ff[2] >= corner_ff[0]) ? corner_ff[2] - corner_ff[0] : '0;

   // shared multiplier
   always_comb begin
      unique case (cmd.op)
         pbb_pkg::OP_SQR_MUL: begin
            mul_a = CW'($unsigned(r_ff[cidx]));
            mul_b = CW'($unsigned(r_ff[cidx]));
         end
         pbb_pkg::OP_PEN_MUL: begin
            mul_a = diff_y;
            mul_b = diff_y;
         end
         pbb_pkg::OP_TX_MUL: begin
            mul_a = CW'(rnd_x_ff);
            mul_b = diff_x;
         end
         pbb_pkg::OP_TY_MUL: begin
            mul_a = CW'(rnd_y_ff);
            mul_b = CW'(root_hx_ff);
         end
         pbb_pkg::OP_TE_MUL: begin
            mul_a = ae_ff;
            mul_b = ae_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // one trim bound per step, in root space
   always_comb begin
      for (int i = 0; i < pbb_pkg::CORNERS; i++) r_in[i] = r_ff[i];
      unique case (cmd.idx)
         3'd0: if (r_ff[3] > ONE + r_ff[2]) r_in[3] = ONE + r_ff[2];
         3'd1: if (r_ff[1] - ONE > r_ff[0]) r_in[0] = r_ff[1] - ONE;
         3'd2: if (r_ff[0] - ONE > r_ff[1]) r_in[1] = r_ff[0] - ONE;
         3'd3: if (r_ff[3] + ONE < r_ff[2]) r_in[2] = r_ff[3] + ONE;
         3'd4: if (ONE - r_ff[2] > r_ff[1]) r_in[1] = ONE - r_ff[2];
         3'd5: if (ONE - r_ff[3] > r_ff[0]) r_in[0] = ONE - r_ff[3];
         default: ;
      endcase
   end

   assign sq_sat = (|prod_ff[pbb_pkg::PROD_W-1:F+CW]) ? '1 : prod_ff[F +: CW];
   assign x_sum  = {1'b0, corner_ff[0]} + {1'b0, prod_ff[pbb_pkg::RAND_BITS +: CW]};
   assign t_val  = prod_ff[pbb_pkg::RAND_BITS-2 +: CW];
   assign e_val  = {1'b0, t_val} - (CW+1)'({root_hx_ff, 1'b0});
   assign y_val  = YW'(ONE) - YW'({root_hx_ff, 1'b0}) + YW'(t_val) + YW'(x_ff);

   always_comb begin
      stat.root_done = root_done;
      stat.empty     = !(r_ff[3] > r_ff[1] && r_ff[2] > r_ff[0]);
      stat.full      = full_ff;
      stat.par_mode  = (mode_ff == pbb_pkg::MODE_PAR);
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         pbb_pkg::OP_LOAD: begin
            box_ff[0] <= box_low_x;
            box_ff[1] <= box_low_y;
            box_ff[2] <= box_high_x;
            box_ff[3] <= box_high_y;
            rnd_x_ff  <= rand_x;
            rnd_y_ff  <= rand_y;
            x_ff      <= '0;
            y_ff      <= '0;
         end
         pbb_pkg::OP_ROOT_STORE: begin
            if (cmd.idx != pbb_pkg::XROOT_IDX) r_ff[cidx] <= TW'(root_val);
         end
         pbb_pkg::OP_TRIM: begin
            for (int i = 0; i < pbb_pkg::CORNERS; i++) r_ff[i] <= r_in[i];
         end
         pbb_pkg::OP_CHECK: begin
            full_ff <= (r_ff[3] <= ONE + r_ff[0]) && (r_ff[1] >= ONE - r_ff[0]) &&
                       (r_ff[1] >= r_ff[2] - ONE);
         end
         pbb_pkg::OP_SQR_MUL, pbb_pkg::OP_PEN_MUL, pbb_pkg::OP_TX_MUL,
         pbb_pkg::OP_TY_MUL, pbb_pkg::OP_TE_MUL: begin
            prod_ff <= mul_p;
         end
         pbb_pkg::OP_PEN_SCALE: begin
            // 25 * d^2 against 576 * x1 * 2^F
            pen_rhs_ff <= pbb_pkg::PEN_W'({prod_ff, 4'b0}) + pbb_pkg::PEN_W'({prod_ff, 3'b0})
                          + pbb_pkg::PEN_W'(prod_ff);
            pen_lhs_ff <= (pbb_pkg::PEN_W'({corner_ff[2], 9'b0})
                           + pbb_pkg::PEN_W'({corner_ff[2], 6'b0})) << F;
         end
         pbb_pkg::OP_TX_ADD: begin
            x_ff <= (x_sum > (CW+1)'(corner_ff[2])) ? corner_ff[2] : x_sum[CW-1:0];
         end
         pbb_pkg::OP_TY_ADD: begin
            y_ff  <= $signed(y_val);
            ae_ff <= e_val[CW] ? CW'(-e_val) : e_val[CW-1:0];
         end
         pbb_pkg::OP_PUBLISH: begin
            out_mode_ff <= mode_ff;
            for (int i = 0; i < pbb_pkg::CORNERS; i++) out_corner_ff[i] <= corner_ff[i];
            out_x_ff   <= x_ff;
            out_y_ff   <= POINT_Y_W_L'(y_ff);
            out_acc_ff <= acc_ff;
         end
         default: ;
      endcase
   end

   // stored box state and trial flag; reset to an unable box
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pbb_pkg::CORNERS; i++) corner_ff[i] <= '0;
         mode_ff    <= pbb_pkg::MODE_UNABLE;
         root_hx_ff <= '0;
         acc_ff     <= 1'b0;
      end else begin
         unique case (cmd.op)
            pbb_pkg::OP_LOAD: acc_ff <= 1'b0;
            pbb_pkg::OP_CLEAR: begin
               for (int i = 0; i < pbb_pkg::CORNERS; i++) corner_ff[i] <= '0;
               mode_ff    <= pbb_pkg::MODE_UNABLE;
               root_hx_ff <= '0;
            end
            pbb_pkg::OP_SQR_WR: corner_ff[cidx] <= sq_sat;
            pbb_pkg::OP_ROOT_STORE: begin
               if (cmd.idx == pbb_pkg::XROOT_IDX) root_hx_ff <= root_val;
            end
            pbb_pkg::OP_FULL_MODE: mode_ff <= pbb_pkg::MODE_FULL;
            pbb_pkg::OP_PEN_CMP: begin
               mode_ff <= (pen_lhs_ff < pen_rhs_ff) ? pbb_pkg::MODE_PAR : pbb_pkg::MODE_BOX;
            end
            pbb_pkg::OP_T_ACC: begin
               acc_ff <= (y_ff >= $signed(YW'(corner_ff[1]))) &&
                         (y_ff <= $signed(YW'(corner_ff[3]))) &&
                         (prod_ff < (pbb_pkg::PROD_W'(x_ff) << (F + 2)));
            end
            default: ;
         endcase
      end
   end

   assign sample_mode = out_mode_ff;
   assign trim_low_x  = out_corner_ff[0];
   assign trim_low_y  = out_corner_ff[1];
   assign trim_high_x = out_corner_ff[2];
   assign trim_high_y = out_corner_ff[3];
   assign point_x     = out_x_ff;
   assign point_y     = out_y_ff;
   assign accepted    = out_acc_ff;

   pen_sets_reject_mode: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == pbb_pkg::OP_PEN_CMP) |=>
         (mode_ff == pbb_pkg::MODE_PAR || mode_ff == pbb_pkg::MODE_BOX))
      else $error("penalty compare left a non-reject mode");

   acc_only_in_par_mode: assert property (@(posedge clock) disable iff (reset)
      acc_ff |-> (mode_ff == pbb_pkg::MODE_PAR))
      else $error("trial accepted outside parallelogram mode");

   clear_leaves_unable: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == pbb_pkg::OP_CLEAR) |=> (mode_ff == pbb_pkg::MODE_UNABLE))
      else $error("cleared box not unable");

endmodule

`default_nettype wire

### rtl/pbb_ctrl.sv
`default_nettype none

module pbb_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_command,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire pbb_pkg::dp_stat_type  stat,
   output pbb_pkg::dp_cmd_type        cmd
);

   typedef enum logic [16:0] {
      ST_IDLE      = 17'h00001,
      ST_ROOT_RUN  = 17'h00002,
      ST_ROOT_WAIT = 17'h00004,
      ST_TRIM      = 17'h00008,
      ST_CHECK     = 17'h00010,
      ST_SQR_MUL   = 17'h00020,
      ST_SQR_WR    = 17'h00040,
      ST_PEN_MUL   = 17'h00080,
      ST_PEN_SCALE = 17'h00100,
      ST_PEN_CMP   = 17'h00200,
      ST_TX_MUL    = 17'h00400,
      ST_TX_ADD    = 17'h00800,
      ST_TY_MUL    = 17'h01000,
      ST_TY_ADD    = 17'h02000,
      ST_TE_MUL    = 17'h04000,
      ST_T_ACC     = 17'h08000,
      ST_DONE      = 17'h10000
   } state_type;

   state_type                 state_ff, state_in;
   logic [pbb_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = pbb_pkg::OP_NONE;
      cmd.idx      = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op = pbb_pkg::OP_LOAD;
               if (req_command == pbb_pkg::CMD_LOAD) begin
                  idx_in   = '0;
                  state_in = ST_ROOT_RUN;
               end else if (stat.par_mode) begin
                  state_in = ST_TX_MUL;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_ROOT_RUN: begin
            cmd.op   = pbb_pkg::OP_ROOT_START;
            state_in = ST_ROOT_WAIT;
         end
         ST_ROOT_WAIT: begin
            if (stat.root_done) begin
               cmd.op = pbb_pkg::OP_ROOT_STORE;
               if (idx_ff == pbb_pkg::XROOT_IDX) begin
                  state_in = ST_PEN_MUL;
               end else if (idx_ff == pbb_pkg::LAST_CORNER) begin
                  idx_in   = '0;
                  state_in = ST_TRIM;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_ROOT_RUN;
               end
            end
         end
         ST_TRIM: begin
            cmd.op = pbb_pkg::OP_TRIM;
            if (idx_ff == pbb_pkg::LAST_TRIM) begin
               state_in = ST_CHECK;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_CHECK: begin
            if (stat.empty) begin
               cmd.op   = pbb_pkg::OP_CLEAR;
               state_in = ST_DONE;
            end else begin
               cmd.op   = pbb_pkg::OP_CHECK;
               idx_in   = '0;
               state_in = ST_SQR_MUL;
            end
         end
         ST_SQR_MUL: begin
            cmd.op   = pbb_pkg::OP_SQR_MUL;
            state_in = ST_SQR_WR;
         end
         ST_SQR_WR: begin
            cmd.op = pbb_pkg::OP_SQR_WR;
            if (idx_ff == pbb_pkg::LAST_CORNER) begin
               idx_in   = pbb_pkg::XROOT_IDX;
               state_in = ST_ROOT_RUN;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SQR_MUL;
            end
         end
         ST_PEN_MUL: begin
            if (stat.full) begin
               cmd.op   = pbb_pkg::OP_FULL_MODE;
               state_in = ST_DONE;
            end else begin
               cmd.op   = pbb_pkg::OP_PEN_MUL;
               state_in = ST_PEN_SCALE;
            end
         end
         ST_PEN_SCALE: begin
            cmd.op   = pbb_pkg::OP_PEN_SCALE;
            state_in = ST_PEN_CMP;
         end
         ST_PEN_CMP: begin
            cmd.op   = pbb_pkg::OP_PEN_CMP;
            state_in = ST_DONE;
         end
         ST_TX_MUL: begin
            cmd.op   = pbb_pkg::OP_TX_MUL;
            state_in = ST_TX_ADD;
         end
         ST_TX_ADD: begin
            cmd.op   = pbb_pkg::OP_TX_ADD;
            state_in = ST_TY_MUL;
         end
         ST_TY_MUL: begin
            cmd.op   = pbb_pkg::OP_TY_MUL;
            state_in = ST_TY_ADD;
         end
         ST_TY_ADD: begin
            cmd.op   = pbb_pkg::OP_TY_ADD;
            state_in = ST_TE_MUL;
         end
         ST_TE_MUL: begin
            cmd.op   = pbb_pkg::OP_TE_MUL;
            state_in = ST_T_ACC;
         end
         ST_T_ACC: begin
            cmd.op   = pbb_pkg::OP_T_ACC;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = pbb_pkg::OP_PUBLISH;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   root_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      stat.root_done |-> (state_ff == ST_ROOT_WAIT))
      else $error("root result arrived outside root wait");

   hold_until_output_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && !rsp_ready) |=>
         (state_ff == ST_DONE && rsp_valid_ff))
      else $error("result published over a pending word");

   load_starts_roots: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_command == pbb_pkg::CMD_LOAD) |=>
         (state_ff == ST_ROOT_RUN && idx_ff == '0))
      else $error("load did not start root sequence");

endmodule

`default_nettype wire

### tb/parabolic_band_box_sampler_tb.sv
`timescale 1ns / 1ps

module parabolic_band_box_sampler_tb;

   // Expected result word, field by field as the response channel carries it.
   typedef struct {
      logic [1:0]  sample_mode;
      logic [31:0] trim_low_x;
      logic [31:0] trim_low_y;
      logic [31:0] trim_high_x;
      logic [31:0] trim_high_y;
      logic [31:0] point_x;
      logic [39:0] point_y;
      logic        accepted;
   } sample_word_type;

   localparam longint ONE_Q = 64'sd1 << pbb_pkg::COORD_FRAC_BITS;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock;
   logic reset;

   pbb_req_if req_chan ();
   pbb_rsp_if rsp_chan ();

   parabolic_band_box_sampler dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   // Predictor state: a copy of what the block keeps between words.
   logic [31:0]       pred_corner [4];
   pbb_pkg::mode_type pred_mode;
   logic [31:0]       pred_root_x1;

   sample_word_type expected_words [$];
   int  mismatch_count;
   int  idle_cycles;
   int  loads_sent;
   int  trials_sent;
   int  par_trials;
   int  accepted_seen;
   int  stall_left;
   bit  idle_enable;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // floor(sqrt(x * 2^F)) for a 32-bit x.
   function automatic logic [31:0] root_q(input logic [31:0] x);
      logic [127:0] val;
      logic [127:0] root;
      logic [127:0] bitv;
      val  = 128'(x) << pbb_pkg::COORD_FRAC_BITS;
      root = '0;
      for (int k = 31; k >= 0; k--) begin
         bitv = root | (128'd1 << k);
         if (bitv * bitv <= val) begin
            root = bitv;
         end
      end
      return root[31:0];
   endfunction

   // floor(u*u / 2^F), saturated to 32 bits.
   function automatic logic [31:0] square_q(input longint u);
      logic [127:0] prod;
      prod = (128'(u) * 128'(u)) >> pbb_pkg::COORD_FRAC_BITS;
      return (prod > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
   endfunction

   function automatic longint max_q(input longint a, input longint b);
      return a > b ? a : b;
   endfunction

   function automatic longint min_q(input longint a, input longint b);
      return a < b ? a : b;
   endfunction

   // Trim a box in root space, update the stored state and classify it.
   function automatic void predict_load(input logic [31:0] lx, input logic [31:0] ly,
                                        input logic [31:0] hx, input logic [31:0] hy);
      longint u0, v0, u1, v1;
      logic [31:0] rx1, ry0, ry1, dy;
      logic [127:0] lhs, rhs;
      bit full;
      u0 = root_q(lx);
      v0 = root_q(ly);
      u1 = root_q(hx);
      v1 = root_q(hy);
      v1 = min_q(v1, ONE_Q + u1);
      u0 = max_q(u0, v0 - ONE_Q);
      v0 = max_q(v0, u0 - ONE_Q);
      u1 = min_q(u1, v1 + ONE_Q);
      v0 = max_q(v0, ONE_Q - u1);
      u0 = max_q(u0, ONE_Q - v1);
      if (!(v1 > v0 && u1 > u0)) begin
         foreach (pred_corner[i]) pred_corner[i] = '0;
         pred_mode    = pbb_pkg::MODE_UNABLE;
         pred_root_x1 = '0;
         return;
      end
      full = (v1 <= ONE_Q + u0) && (v0 >= ONE_Q - u0) && (v0 >= u1 - ONE_Q);
      pred_corner[0] = square_q(u0);
      pred_corner[1] = square_q(v0);
      pred_corner[2] = square_q(u1);
      pred_corner[3] = square_q(v1);
      rx1 = pred_corner[2];
      ry0 = pred_corner[1];
      ry1 = pred_corner[3];
      pred_root_x1 = root_q(rx1);
      if (full) begin
         pred_mode = pbb_pkg::MODE_FULL;
         return;
      end
      dy  = (ry1 >= ry0) ? ry1 - ry0 : 32'd0;
      // penalty (4 * 1.2)^2 * x1 < dy^2, scaled to integers
      lhs = 128'd576 * 128'(rx1) * 128'(ONE_Q);
      rhs = 128'd25 * 128'(dy) * 128'(dy);
      pred_mode = (lhs < rhs) ? pbb_pkg::MODE_PAR : pbb_pkg::MODE_BOX;
   endfunction

   // One parallelogram trial from the stored box.
   function automatic void predict_trial(input logic [23:0] rx, input logic [23:0] ry,
                                         inout sample_word_type w);
      longint x0, y0, x1, y1, s, x, y, e;
      logic [127:0] t, lhs, rhs;
      if (pred_mode != pbb_pkg::MODE_PAR) begin
         return;
      end
      x0 = pred_corner[0];
      y0 = pred_corner[1];
      x1 = pred_corner[2];
      y1 = pred_corner[3];
      s  = pred_root_x1;
      x  = x0 + ((longint'(rx) * ((x1 >= x0) ? x1 - x0 : 0)) >>> pbb_pkg::RAND_BITS);
      if (x > x1) begin
         x = x1;
      end
      t = (128'(ry) * 128'(s)) >> (pbb_pkg::RAND_BITS - 2);
      y = ONE_Q - 2 * s + longint'(t[63:0]) + x;
      e = y - ONE_Q - x;
      if (e < 0) begin
         e = -e;
      end
      lhs = 128'(e) * 128'(e);
      rhs = 128'(4 * x) * 128'(ONE_Q);
      w.accepted = (y >= y0) && (y <= y1) && (lhs < rhs);
      if (y > 64'sh7F_FFFF_FFFF) begin
         y = 64'sh7F_FFFF_FFFF;
      end
      w.point_x = x[31:0];
      w.point_y = y[39:0];
      par_trials++;
   endfunction

   function automatic sample_word_type predict_word(input logic cmd,
         input logic [31:0] lx, input logic [31:0] ly, input logic [31:0] hx,
         input logic [31:0] hy, input logic [23:0] rx, input logic [23:0] ry);
      sample_word_type w;
      w.point_x  = '0;
      w.point_y  = '0;
      w.accepted = 1'b0;
      if (cmd == pbb_pkg::CMD_LOAD) begin
         predict_load(lx, ly, hx, hy);
      end else begin
         predict_trial(rx, ry, w);
      end
      w.sample_mode = pred_mode;
      w.trim_low_x  = pred_corner[0];
      w.trim_low_y  = pred_corner[1];
      w.trim_high_x = pred_corner[2];
      w.trim_high_y = pred_corner[3];
      return w;
   endfunction

   // Send one word at a falling edge: optional gap first, then hold valid
   // until accepted. Returns at the falling edge after the accepting edge.
   task automatic send_word(input logic cmd, input logic [31:0] lx, input logic [31:0] ly,
                            input logic [31:0] hx, input logic [31:0] hy,
                            input logic [23:0] rx, input logic [23:0] ry);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.command    <= cmd;
      req_chan.box_low_x  <= lx;
      req_chan.box_low_y  <= ly;
      req_chan.box_high_x <= hx;
      req_chan.box_high_y <= hy;
      req_chan.rand_x     <= rx;
      req_chan.rand_y     <= ry;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      expected_words.push_back(predict_word(cmd, lx, ly, hx, hy, rx, ry));
      if (cmd == pbb_pkg::CMD_LOAD) loads_sent++;
      else trials_sent++;
      @(negedge clock);
   endtask

   task automatic send_load(input logic [31:0] lx, input logic [31:0] ly,
                            input logic [31:0] hx, input logic [31:0] hy);
      send_word(pbb_pkg::CMD_LOAD, lx, ly, hx, hy, 24'($urandom), 24'($urandom));
   endtask

   task automatic send_trial(input logic [23:0] rx, input logic [23:0] ry);
      send_word(pbb_pkg::CMD_TRIAL, $urandom, $urandom, $urandom, $urandom, rx, ry);
   endtask

   // A random corner pair, mostly in the interesting range near the band.
   task automatic pick_span(output logic [31:0] lo, output logic [31:0] hi);
      logic [31:0] a, b;
      case ($urandom_range(0, 4))
         0: begin
            a = $urandom;
            b = $urandom;
         end
         1: begin
            a = $urandom_range(0, 32'h0800_0000);
            b = a + $urandom_range(0, 32'h0400_0000);
         end
         default: begin
            a = $urandom_range(0, 32'h0400_0000);
            b = a + $urandom_range(32'h0010_0000, 32'h0800_0000);
         end
      endcase
      // reverse now and then; the block must trim it to empty
      if ($urandom_range(0, 9) == 0) begin
         lo = b;
         hi = a;
      end else begin
         lo = (a < b) ? a : b;
         hi = (a < b) ? b : a;
      end
   endtask

   task automatic test_reset_trial();
      // trial on the reset state: unable box, nothing drawn
      send_trial(24'hFF_FFFF, 24'hFF_FFFF);
   endtask

   task automatic test_directed_boxes();
      send_load(32'h0, 32'h0, 32'h0, 32'h0);
      send_trial(24'h0, 24'h0);
      send_load(32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_trial(24'hFF_FFFF, 24'h0);
      // reversed corners trim to empty
      send_load(32'h0400_0000, 32'h0400_0000, 32'h0100_0000, 32'h0100_0000);
      // box far away from the band
      send_load(32'h0, 32'h4000_0000, 32'h0010_0000, 32'h5000_0000);
      // small box around x = 1, y = 1: fully inside
      send_load(32'h00F0_0000, 32'h00F0_0000, 32'h0110_0000, 32'h0110_0000);
      send_trial(24'h80_0000, 24'h80_0000);
      // tall thin box: parallelogram mode
      send_load(32'h0000_1000, 32'h0, 32'h0001_0000, 32'h0400_0000);
      send_trial(24'h0, 24'h0);
      send_trial(24'hFF_FFFF, 24'hFF_FFFF);
      send_trial(24'h0, 24'hFF_FFFF);
      send_trial(24'hFF_FFFF, 24'h0);
      send_trial(24'h55_5555, 24'hAA_AAAA);
      // wide box: box rejection
      send_load(32'h0, 32'h0, 32'h0400_0000, 32'h0100_0000);
      send_trial(24'h12_3456, 24'h65_4321);
      send_load(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_load(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
   endtask

   // Loads, each followed by a burst of zero to eight trials, so parallelogram mode is used.
   task automatic test_random_mix(input int word_count);
      logic [31:0] lx, ly, hx, hy;
      int sent;
      sent = 0;
      while (sent < word_count) begin
         pick_span(lx, hx);
         pick_span(ly, hy);
         if ($urandom_range(0, 2) != 0) begin
            // thin in x, tall in y favors parallelogram mode
            lx = $urandom_range(0, 32'h0020_0000);
            hx = lx + $urandom_range(1, 32'h0020_0000);
         end
         send_load(lx, ly, hx, hy);
         sent++;
         repeat ($urandom_range(0, 8)) begin
            send_trial(24'($urandom), 24'($urandom));
            sent++;
         end
      end
   endtask

   // Response side: random stall bursts, then compare each taken word.
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
      end else if (!idle_enable) begin
         rsp_chan.ready <= 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left = $urandom_range(0, 5);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      sample_word_type w;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("ERROR %0t: result word with nothing expected", $realtime);
            end
         end else begin
            w = expected_words.pop_front();
            if (rsp_chan.accepted) accepted_seen++;
            if (rsp_chan.sample_mode !== w.sample_mode ||
                rsp_chan.trim_low_x  !== w.trim_low_x  ||
                rsp_chan.trim_low_y  !== w.trim_low_y  ||
                rsp_chan.trim_high_x !== w.trim_high_x ||
                rsp_chan.trim_high_y !== w.trim_high_y ||
                rsp_chan.point_x     !== w.point_x     ||
                rsp_chan.point_y     !== w.point_y     ||
                rsp_chan.accepted    !== w.accepted) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("ERROR %0t: exp mode %0d trim %h %h %h %h pt %h %h acc %0d",
                           $realtime, w.sample_mode, w.trim_low_x, w.trim_low_y,
                           w.trim_high_x, w.trim_high_y, w.point_x, w.point_y,
                           w.accepted);
                  $display("             got mode %0d trim %h %h %h %h pt %h %h acc %0d",
                           rsp_chan.sample_mode, rsp_chan.trim_low_x,
                           rsp_chan.trim_low_y, rsp_chan.trim_high_x,
                           rsp_chan.trim_high_y, rsp_chan.point_x, rsp_chan.point_y,
                           rsp_chan.accepted);
               end
            end
         end
      end
   end

   // Watchdog: count cycles in which neither channel moves a word.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      reset               = 1'b1;
      idle_enable         = 1'b1;
      mismatch_count      = 0;
      idle_cycles         = 0;
      loads_sent          = 0;
      trials_sent         = 0;
      par_trials          = 0;
      accepted_seen       = 0;
      stall_left          = 0;
      req_chan.valid      = 1'b0;
      req_chan.command    = pbb_pkg::CMD_LOAD;
      req_chan.box_low_x  = '0;
      req_chan.box_low_y  = '0;
      req_chan.box_high_x = '0;
      req_chan.box_high_y = '0;
      req_chan.rand_x     = '0;
      req_chan.rand_y     = '0;
      rsp_chan.ready      = 1'b0;
      foreach (pred_corner[i]) pred_corner[i] = '0;
      pred_mode    = pbb_pkg::MODE_UNABLE;
      pred_root_x1 = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_trial();
      test_directed_boxes();
      test_random_mix(400);
      // last stretch runs back to back
      idle_enable = 1'b0;
      test_random_mix(100);
      req_chan.valid <= 1'b0;

      while (expected_words.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("Sent %0d loads and %0d trials (%0d in parallelogram mode, %0d accepted).",
               loads_sent, trials_sent, par_trials, accepted_seen);
      $display("Mismatches: %0d", mismatch_count);
      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
